FILE: sv/rpwc_pkg.sv
// Package for the RC pulse width capture block: item types, register
// indexes and sizing constants. No dependencies.
package rpwc_pkg;

  // Number of PWM input channels and the index width into the rise-time store
  localparam int MaxChannels = 16;
  localparam int ChIdxW      = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  // Reset values and fixed scale factor
  localparam logic [15:0] SyncReset = 16'd7000;
  localparam logic [15:0] FrcScale  = 16'd35556;
  localparam logic [4:0]  SlotsReset = 5'd8;

  // Configuration port sizing
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgAddrW-1:0] {
    REG_PPM_MODE      = 3'd0,
    REG_SCALE_SELECT  = 3'd1,
    REG_FS_CHANNEL    = 3'd2,
    REG_FS_MIN        = 3'd3,
    REG_FS_MAX        = 3'd4,
    REG_PPM_SLOTS     = 3'd5,
    REG_PPM_ACTIVE    = 3'd6,
    REG_SYNC_THRESH   = 3'd7
  } cfg_reg_e;

  // One edge event
  typedef struct packed {
    logic [4:0]  channel;
    logic        pin_level;
    logic [15:0] timestamp;
  } rpwc_in_t;

  // One measured pulse
  typedef struct packed {
    logic [4:0]  out_channel;
    logic [15:0] pulse_width;
    logic [15:0] good_pulse_count;
    logic        radio_lost;
  } rpwc_out_t;

endpackage

FILE: sv/rc_pulse_width_capture.sv
// Top level of the RC pulse width capture block: config registers, input
// register, decode logic and result register. Uses rpwc_pkg and rpwc_scale.
//
// Usage:
//   Edge events enter on the in_* channel (valid/stall); one item is taken at
//   each clock edge where in_valid_i is high and in_stall_o is low. Measured
//   pulses leave on the out_* channel in the same order, zero or one per edge.
//   Configuration is written through cfg_we_i / cfg_addr_i / cfg_wdata_i while
//   the block is idle; writes take effect at the next clock edge.
// Pipeline and throughput:
//   An item waits in the input register; its result, if any, is loaded into
//   the result register as the item leaves it, which raises out_valid_o.
//   One item per cycle is sustained while out_stall_i holds no result:
//   subtract, scale multiply and window compare sit in the single stage
//   between the two registers; per-channel state updates in the same cycle.
// Stall:
//   When out_stall_i holds a pending result, the input register stops and
//   in_stall_o rises once it is full; nothing is dropped.
// Reset:
//   rst_ni clears rise times, the good count, the PPM slot and last edge,
//   both valid flags, and loads the register reset values.
module rc_pulse_width_capture (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  rpwc_pkg::rpwc_in_t       in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output rpwc_pkg::rpwc_out_t      out_item_o,
  input  logic                     cfg_we_i,
  input  logic [rpwc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [rpwc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rpwc_pkg::*;

  localparam logic [5:0] MaxChL = 6'(MaxChannels);

  // Configuration registers
  logic        ppm_mode_q, scale_sel_q, active_lvl_q;
  logic [4:0]  fs_channel_q, ppm_slots_q;
  logic [15:0] fs_min_q, fs_max_q, sync_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppm_mode_q   <= 1'b0;
      scale_sel_q  <= 1'b0;
      fs_channel_q <= 5'd0;
      fs_min_q     <= 16'd0;
      fs_max_q     <= 16'hFFFF;
      ppm_slots_q  <= SlotsReset;
      active_lvl_q <= 1'b1;
      sync_thr_q   <= SyncReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_PPM_MODE:     ppm_mode_q   <= cfg_wdata_i[0];
        REG_SCALE_SELECT: scale_sel_q  <= cfg_wdata_i[0];
        REG_FS_CHANNEL:   fs_channel_q <= cfg_wdata_i[4:0];
        REG_FS_MIN:       fs_min_q     <= cfg_wdata_i;
        REG_FS_MAX:       fs_max_q     <= cfg_wdata_i;
        REG_PPM_SLOTS:    ppm_slots_q  <= cfg_wdata_i[4:0];
        REG_PPM_ACTIVE:   active_lvl_q <= cfg_wdata_i[0];
        REG_SYNC_THRESH:  sync_thr_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: input register moves on when the result register can load
  logic      s1_valid_q, out_valid_q;
  rpwc_in_t  s1_q;
  rpwc_out_t out_q;
  logic      out_load, s1_fire;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_item_i;
    end
  end

  // Decoder state
  logic [15:0] rise_q [MaxChannels];
  logic [15:0] good_q, good_d;
  logic [4:0]  slot_q, slot_d;
  logic [15:0] last_edge_q;

  // Width measurement
  logic [ChIdxW-1:0] ch_idx;
  logic [15:0]       raw, width;
  logic              ch_ok, in_win;

  assign ch_idx = ChIdxW'(s1_q.channel - 5'd1);
  assign ch_ok  = (s1_q.channel != 5'd0) && ({1'b0, s1_q.channel} <= MaxChL);
  assign raw    = ppm_mode_q ? (s1_q.timestamp - last_edge_q)
                             : (s1_q.timestamp - rise_q[ch_idx]);

  rpwc_scale u_scale (
    .raw_i       (raw),
    .scale_sel_i (scale_sel_q),
    .width_o     (width)
  );

  assign in_win = (width > fs_min_q) && (width < fs_max_q);

  // Per-item decision
  logic        emit, lost, rise_we, edge_we, fs_hit;
  logic [4:0]  emit_ch;

  always_comb begin
    emit    = 1'b0;
    lost    = 1'b0;
    rise_we = 1'b0;
    edge_we = 1'b0;
    fs_hit  = 1'b0;
    emit_ch = s1_q.channel;
    good_d  = good_q;
    slot_d  = slot_q;
    if (!ppm_mode_q) begin
      if (ch_ok && s1_q.pin_level) begin
        rise_we = 1'b1;
      end else if (ch_ok) begin
        emit   = 1'b1;
        fs_hit = (s1_q.channel == fs_channel_q);
        if (fs_hit && in_win) begin
          good_d = (good_q != 16'hFFFF) ? good_q + 16'd1 : good_q;
        end else if (fs_hit) begin
          good_d = 16'd0;
          lost   = 1'b1;
        end
      end
    end else if (s1_q.pin_level == active_lvl_q) begin
      edge_we = 1'b1;
      if (width > sync_thr_q) begin
        slot_d = 5'd1;
      end else if (slot_q != 5'd0 && slot_q <= ppm_slots_q) begin
        slot_d  = slot_q + 5'd1;
        emit_ch = slot_q;
        if ({1'b0, slot_q} <= MaxChL) begin
          emit   = 1'b1;
          fs_hit = (fs_channel_q != 5'd0) && (slot_q == fs_channel_q);
          if (fs_hit && in_win) begin
            good_d = (good_q != 16'hFFFF) ? good_q + 16'd1 : good_q;
          end
        end
      end
    end
  end

  // State update when the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxChannels; i++) begin
        rise_q[i] <= 16'd0;
      end
      good_q      <= 16'd0;
      slot_q      <= 5'd0;
      last_edge_q <= 16'd0;
    end else if (s1_fire) begin
      if (rise_we) begin
        rise_q[ch_idx] <= s1_q.timestamp;
      end
      if (edge_we) begin
        last_edge_q <= s1_q.timestamp;
      end
      good_q <= good_d;
      slot_q <= slot_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      out_q.out_channel      <= emit_ch;
      out_q.pulse_width      <= width;
      out_q.good_pulse_count <= good_d;
      out_q.radio_lost       <= lost;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: sv/rpwc_scale.sv
// Width scaler: halves the raw width or applies the fixed fractional gain.
// Depends on rpwc_pkg for the scale constant.
module rpwc_scale (
  input  logic [15:0] raw_i,
  input  logic        scale_sel_i,
  output logic [15:0] width_o
);
  import rpwc_pkg::*;

  logic [15:0] doubled;
  logic [31:0] product;

  // ((w << 1) mod 2^16) * gain, keep the upper half
  assign doubled = {raw_i[14:0], 1'b0};
  assign product = doubled * FrcScale;

  assign width_o = scale_sel_i ? product[31:16] : {1'b0, raw_i[15:1]};

endmodule

FILE: sv/rpwc_checker.sv
// Port-level checks for rc_pulse_width_capture, attached by bind.
// Depends on rpwc_pkg for the channel count.
module rpwc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rpwc_pkg::rpwc_out_t out_item_o
);
  import rpwc_pkg::*;

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Radio loss always comes with a cleared good count
  a_lost_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.radio_lost |-> out_item_o.good_pulse_count == 16'd0)
    else $error("radio loss without cleared count");

  // Reported channel is a real channel
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.out_channel != 5'd0 &&
                    {1'b0, out_item_o.out_channel} <= 6'(MaxChannels))
    else $error("result channel out of range");

  // No result shows in the cycle after reset was seen
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind rc_pulse_width_capture rpwc_checker u_rpwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
